FILE: rtl/core/tsn_pkg.sv
// ============================================================================
// tsn_pkg
// shared constants and types for the trajectory speed normalizer
// ============================================================================
package tsn_pkg;

    localparam int MAX_POINTS_DEF = 256;
    localparam logic [31:0] YAW_START = 32'hFFFF_D300;
    localparam logic signed [31:0] YAW_HALF = 32'sd23040;
    localparam logic [31:0] YAW_FULL = 32'd46080;
    localparam logic [14:0] TOP_SPEED_RST = 15'd256;

    localparam logic [1:0] REG_TOP_SPEED = 2'd0;
    localparam logic [1:0] REG_YAW_RATE = 2'd1;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_SQ    = 10'b0000000010,
        ST_SQRT  = 10'b0000000100,
        ST_TDIV  = 10'b0000001000,
        ST_VSET  = 10'b0000010000,
        ST_VDIV  = 10'b0000100000,
        ST_STORE = 10'b0001000000,
        ST_RD    = 10'b0010000000,
        ST_YAW   = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;

endpackage

FILE: rtl/core/trajectory_speed_normalizer_top.sv
// ============================================================================
// trajectory_speed_normalizer_top
// rescales trajectory velocities to top speed, tracks yaw, replays return path
// ============================================================================
// forward word: squares of the three components, square root, time divide,
// three velocity divides, then store, yaw update and output; zero top speed
// gives zero velocities and full duration; replay word: registered read, negated
// a word with zero speed or zero duration is dropped and frees the unit
// one word in flight, ready again the cycle after the result is taken
// rst_n async low: yaw to -90 deg, count and replay index to zero; store not reset
module trajectory_speed_normalizer_top
    import tsn_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic signed [15:0] vel_x,
    input  logic signed [15:0] vel_y,
    input  logic signed [15:0] vel_z,
    input  logic [15:0]        seg_time,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] out_vel_x,
    output logic signed [15:0] out_vel_y,
    output logic signed [15:0] out_vel_z,
    output logic [15:0]        out_time,
    output logic signed [31:0] heading,
    output logic               is_return,
    output logic               last_point,
    output logic               buffer_full
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] MAXP = CW'(MAX_POINTS);

    logic [14:0] top_reg;
    logic [15:0] rate_reg;
    state_t      st_reg;
    logic [31:0] yaw_reg;
    logic [CW-1:0] cnt_reg, rix_reg;

    logic [63:0] mem [MAX_POINTS];
    logic [63:0] rd_reg;

    logic signed [15:0] v_reg [3];
    logic [1:0]  vi_reg;
    logic [33:0] sum_reg;
    logic [16:0] m_reg;
    // shared shift-subtract unit: remainder, working value, quotient
    logic [34:0] rem_reg;
    logic [35:0] num_reg;
    logic [35:0] q_reg;
    logic [5:0]  it_reg;
    logic [15:0] dur_reg;
    logic signed [15:0] ov_reg [3];
    logic        ret_reg, last_reg, full_reg, ovalid_reg;

    logic wr;
    assign pready = 1'b1;
    assign wr = psel & penable & pwrite;
    always_comb
    begin
        unique case (paddr[2])
            1'b0:    prdata = {17'd0, top_reg};
            default: prdata = {16'd0, rate_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg  <= TOP_SPEED_RST;
            rate_reg <= '0;
        end
        else if (wr)
        begin
            if (paddr[2] == REG_TOP_SPEED[0]) top_reg <= pwdata[14:0];
            if (paddr[2] == REG_YAW_RATE[0])  rate_reg <= pwdata[15:0];
        end
    end

    assign in_ready = (st_reg == ST_IDLE) && !ovalid_reg;

    // sqrt step
    logic [34:0] sq_trial;
    logic [34:0] sq_rem;
    assign sq_rem   = {rem_reg[32:0], num_reg[35:34]};
    assign sq_trial = {16'd0, q_reg[16:0], 2'b01};
    // divide step: divisor is 2*top in the time divide, 2*m in the velocity divides
    logic [35:0] dv_rem;
    logic [35:0] dv_den;
    logic [35:0] dv_sub;
    assign dv_rem = {rem_reg, num_reg[35]};
    assign dv_sub = dv_rem - dv_den;

    logic [15:0] mag;
    logic [15:0] cur_v;
    assign cur_v = v_reg[vi_reg];
    assign mag = cur_v[15] ? 16'(-cur_v) : cur_v;

    logic [32:0] tprod;
    logic [30:0] vprod;
    assign tprod = dur_reg * m_reg;
    assign vprod = mag * top_reg;

    always_comb
    begin
        if (st_reg == ST_TDIV) dv_den = {20'd0, top_reg, 1'b0};
        else                   dv_den = {18'd0, m_reg, 1'b0};
    end

    logic signed [15:0] vsat;
    always_comb
    begin
        // q magnitude at most 32767*65535, saturate
        if (cur_v[15])
            vsat = (q_reg[35:15] != '0) ? -16'sd32768 : 16'(-q_reg[15:0]);
        else
            vsat = (q_reg[35:15] != '0) ? 16'sd32767 : q_reg[15:0];
    end

    logic [31:0] prod;
    logic [31:0] yaw_add;
    logic signed [31:0] yaw_sum;
    assign prod    = dur_reg * rate_reg;
    assign yaw_add = 32'(({1'b0, prod} + 33'd256) >> 9);
    assign yaw_sum = yaw_reg + yaw_add;

    function automatic logic signed [15:0] neg_sat(input logic [15:0] v);
        neg_sat = (v == 16'h8000) ? 16'sd32767 : 16'(-v);
    endfunction

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_STORE && !full_reg)
            mem[cnt_reg[AW-1:0]] <= {dur_reg, ov_reg[2], ov_reg[1], ov_reg[0]};
        rd_reg <= mem[rix_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            yaw_reg    <= YAW_START;
            cnt_reg    <= '0;
            rix_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && out_ready) ovalid_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        if (req_type)
                        begin
                            if (rix_reg < cnt_reg) st_reg <= ST_RD;
                        end
                        else
                        begin
                            v_reg[0] <= vel_x;
                            v_reg[1] <= vel_y;
                            v_reg[2] <= vel_z;
                            dur_reg  <= seg_time;
                            vi_reg   <= 2'd0;
                            sum_reg  <= '0;
                            st_reg   <= ST_SQ;
                        end
                    end
                end
                ST_SQ:
                begin
                    sum_reg <= sum_reg + 34'($signed(cur_v) * $signed(cur_v));
                    if (vi_reg == 2'd2)
                    begin
                        st_reg  <= ST_SQRT;
                        rem_reg <= '0;
                        q_reg   <= '0;
                        num_reg <= {sum_reg + 34'($signed(cur_v) * $signed(cur_v)), 2'b00};
                        it_reg  <= 6'd17;
                    end
                    else vi_reg <= vi_reg + 2'd1;
                end
                ST_SQRT:
                begin
                    num_reg <= {num_reg[33:0], 2'b00};
                    if (sq_rem >= sq_trial)
                    begin
                        rem_reg <= sq_rem - sq_trial;
                        q_reg   <= {q_reg[34:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= sq_rem;
                        q_reg   <= {q_reg[34:0], 1'b0};
                    end
                    it_reg <= it_reg - 6'd1;
                    if (it_reg == 6'd1)
                    begin
                        if (sq_rem >= sq_trial) m_reg <= {q_reg[15:0], 1'b1};
                        else                    m_reg <= {q_reg[15:0], 1'b0};
                        if (q_reg[15:0] == '0 && sq_rem < sq_trial) st_reg <= ST_IDLE;
                        else st_reg <= ST_TDIV;
                    end
                end
                ST_TDIV:
                begin
                    // (2*d*m + top) / (2*top)
                    if (it_reg == 6'd0)
                    begin
                        num_reg <= 36'({tprod, 1'b0} + top_reg);
                        rem_reg <= '0;
                        q_reg   <= '0;
                        it_reg  <= 6'd36;
                        if (top_reg == '0)
                        begin
                            if (dur_reg == '0) st_reg <= ST_IDLE;
                            else
                            begin
                                dur_reg <= 16'hFFFF;
                                vi_reg  <= 2'd0;
                                st_reg  <= ST_VSET;
                            end
                        end
                    end
                    else
                    begin
                        num_reg <= {num_reg[34:0], 1'b0};
                        rem_reg <= dv_sub[35] ? dv_rem[34:0] : dv_sub[34:0];
                        q_reg   <= {q_reg[34:0], ~dv_sub[35]};
                        it_reg  <= it_reg - 6'd1;
                        if (it_reg == 6'd1)
                        begin
                            vi_reg <= 2'd0;
                            if (q_reg[34:15] != '0)
                            begin
                                dur_reg <= 16'hFFFF;
                                st_reg  <= ST_VSET;
                            end
                            else if ({q_reg[14:0], ~dv_sub[35]} == '0) st_reg <= ST_IDLE;
                            else
                            begin
                                dur_reg <= {q_reg[14:0], ~dv_sub[35]};
                                st_reg  <= ST_VSET;
                            end
                        end
                    end
                end
                ST_VSET:
                begin
                    num_reg <= 36'({vprod, 1'b0} + m_reg);
                    rem_reg <= '0;
                    q_reg   <= '0;
                    it_reg  <= 6'd36;
                    if (top_reg == '0)
                    begin
                        ov_reg[vi_reg] <= '0;
                        if (vi_reg == 2'd2) st_reg <= ST_STORE;
                        else vi_reg <= vi_reg + 2'd1;
                    end
                    else st_reg <= ST_VDIV;
                end
                ST_VDIV:
                begin
                    num_reg <= {num_reg[34:0], 1'b0};
                    rem_reg <= dv_sub[35] ? dv_rem[34:0] : dv_sub[34:0];
                    q_reg   <= {q_reg[34:0], ~dv_sub[35]};
                    it_reg  <= it_reg - 6'd1;
                    if (it_reg == 6'd0)
                    begin
                        ov_reg[vi_reg] <= vsat;
                        if (vi_reg == 2'd2) st_reg <= ST_STORE;
                        else
                        begin
                            vi_reg <= vi_reg + 2'd1;
                            st_reg <= ST_VSET;
                        end
                    end
                end
                ST_STORE:
                begin
                    ret_reg  <= 1'b0;
                    last_reg <= 1'b0;
                    if (!full_reg) cnt_reg <= cnt_reg + 1'b1;
                    st_reg <= ST_YAW;
                end
                ST_RD:
                begin
                    // wait for registered read
                    if (it_reg == 6'd63)
                    begin
                        ov_reg[0] <= neg_sat(rd_reg[15:0]);
                        ov_reg[1] <= neg_sat(rd_reg[31:16]);
                        ov_reg[2] <= neg_sat(rd_reg[47:32]);
                        dur_reg   <= rd_reg[63:48];
                        ret_reg   <= 1'b1;
                        last_reg  <= (rix_reg + 1'b1) == cnt_reg;
                        rix_reg   <= rix_reg + 1'b1;
                        st_reg    <= ST_YAW;
                    end
                    it_reg <= 6'd63;
                end
                ST_YAW:
                begin
                    out_vel_x   <= ov_reg[0];
                    out_vel_y   <= ov_reg[1];
                    out_vel_z   <= ov_reg[2];
                    out_time    <= dur_reg;
                    heading     <= yaw_reg;
                    is_return   <= ret_reg;
                    last_point  <= last_reg;
                    buffer_full <= full_reg & ~ret_reg;
                    yaw_reg     <= (yaw_sum > YAW_HALF) ? yaw_sum - YAW_FULL : yaw_sum;
                    st_reg      <= ST_OUT;
                end
                ST_OUT:
                begin
                    ovalid_reg <= 1'b1;
                    st_reg     <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
            if (st_reg == ST_IDLE) it_reg <= 6'd0;
            if (st_reg == ST_SQ) full_reg <= cnt_reg >= MAXP;
        end
    end

    assign out_valid = ovalid_reg;

endmodule

FILE: rtl/core/tsn_checker.sv
// ============================================================================
// tsn_checker
// port-level checks for the trajectory speed normalizer
// ============================================================================
module tsn_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic is_return,
    input logic last_point,
    input logic buffer_full,
    input logic [15:0] out_time
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("ready while result pending");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_point |-> is_return)
        else $error("last on forward word");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && buffer_full |-> !is_return)
        else $error("full on return word");

    a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_return |-> out_time != 16'd0)
        else $error("zero duration emitted");

endmodule

bind trajectory_speed_normalizer_top tsn_checker u_tsn_checker (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .is_return(is_return),
    .last_point(last_point), .buffer_full(buffer_full), .out_time(out_time)
);

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// trajectory speed normalizer testbench
// drives forward points and replay requests through the valid/ready input,
// predicts each result from a local model of scaling, yaw and the point
// store, and checks every output word field by field; the apb port changes
// top speed and yaw rate between phases
// ============================================================================
module testbench;
    import tsn_pkg::*;

    localparam int NPTS = MAX_POINTS_DEF;
    localparam int LIMIT = 3000000;
    localparam int DRAIN = 200;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
        logic [15:0]        tm;
        logic signed [31:0] hd;
        logic               ret;
        logic               last;
        logic               full;
    } point_t;

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 0, in_ready;
    logic req_type = 0;
    logic signed [15:0] vel_x = 0, vel_y = 0, vel_z = 0;
    logic [15:0] seg_time = 0;
    logic out_valid, out_ready = 0;
    logic signed [15:0] out_vel_x, out_vel_y, out_vel_z;
    logic [15:0] out_time;
    logic signed [31:0] heading;
    logic is_return, last_point, buffer_full;

    // predictor state
    logic [14:0] top_speed_q = TOP_SPEED_RST;
    logic [15:0] yaw_rate_q = '0;
    logic [31:0] yaw_q = YAW_START;
    logic [63:0] store_q [NPTS];
    int unsigned count_q = 0;
    int unsigned replay_q = 0;

    point_t pending_q[$];
    int errors = 0;
    int checked = 0;
    int sent = 0;
    int returns_seen = 0;
    int cycles = 0;
    int out_gap = 0;
    bit stall_en = 1;

    trajectory_speed_normalizer_top uut (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [63:0] isqrt(logic [63:0] s);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] scale_velocity(logic signed [15:0] v,
                                                          longint unsigned m);
        longint unsigned mag, q;
        mag = (v < 0) ? -longint'(v) : longint'(v);
        if (top_speed_q == 0) return 0;
        q = (2 * mag * top_speed_q + m) / (2 * m);
        return sat16(v < 0 ? -longint'(q) : longint'(q));
    endfunction

    task automatic advance_heading(logic [15:0] dur);
        longint unsigned p;
        p = longint'(dur) * yaw_rate_q;
        yaw_q = yaw_q + 32'((p + 256) >> 9);
        if ($signed(yaw_q) > YAW_HALF) yaw_q = yaw_q - YAW_FULL;
    endtask

    // returns 1 and the expected word if the input yields a result
    task automatic predict_point(input logic rt, input logic signed [15:0] ix, iy, iz,
                                 input logic [15:0] d, output bit has, output point_t p);
        longint unsigned sum, m, t;
        logic [63:0] w;
        has = 0;
        p = '0;
        if (!rt)
        begin
            sum = longint'(ix) * ix + longint'(iy) * iy + longint'(iz) * iz;
            m = isqrt(sum);
            if (m == 0) return;
            if (top_speed_q == 0) t = (d * m != 0) ? 65535 : 0;
            else
            begin
                t = (2 * longint'(d) * m + top_speed_q) / (2 * longint'(top_speed_q));
                if (t > 65535) t = 65535;
            end
            if (t == 0) return;
            p.vx = scale_velocity(ix, m);
            p.vy = scale_velocity(iy, m);
            p.vz = scale_velocity(iz, m);
            p.tm = t[15:0];
            if (count_q < NPTS)
            begin
                store_q[count_q] = {p.tm, p.vz, p.vy, p.vx};
                count_q++;
            end
            else
                p.full = 1;
        end
        else
        begin
            if (replay_q >= count_q) return;
            w = store_q[replay_q];
            p.vx = sat16(-longint'($signed(w[15:0])));
            p.vy = sat16(-longint'($signed(w[31:16])));
            p.vz = sat16(-longint'($signed(w[47:32])));
            p.tm = w[63:48];
            p.ret = 1;
            p.last = (replay_q + 1 == count_q);
            replay_q++;
        end
        p.hd = yaw_q;
        advance_heading(p.tm);
        has = 1;
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // output side: random wait per word when stalls are enabled, checks each word
    always @(posedge clk)
    begin
        point_t e;
        int g;
        if (out_valid && out_ready)
        begin
            if (pending_q.size() == 0)
                report_mismatch("unexpected word", 1, 0);
            else
            begin
                e = pending_q.pop_front();
                checked++;
                if (is_return) returns_seen++;
                if (out_vel_x !== e.vx) report_mismatch("out_vel_x", out_vel_x, e.vx);
                if (out_vel_y !== e.vy) report_mismatch("out_vel_y", out_vel_y, e.vy);
                if (out_vel_z !== e.vz) report_mismatch("out_vel_z", out_vel_z, e.vz);
                if (out_time !== e.tm) report_mismatch("out_time", out_time, e.tm);
                if (heading !== e.hd) report_mismatch("heading", heading, e.hd);
                if (is_return !== e.ret) report_mismatch("is_return", is_return, e.ret);
                if (last_point !== e.last) report_mismatch("last_point", last_point, e.last);
                if (buffer_full !== e.full)
                    report_mismatch("buffer_full", buffer_full, e.full);
            end
        end
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                g = stall_en ? $urandom_range(0, 19) : 0;
                out_gap <= g;
                out_ready <= (g == 0);
            end
            else if (out_gap != 0)
                out_gap <= out_gap - 1;
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_point(logic rt, logic signed [15:0] ix, iy, iz, logic [15:0] d);
        bit has;
        point_t p;
        int gap;
        gap = stall_en ? $urandom_range(0, 19) : 0;
        if (gap != 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        req_type <= rt;
        vel_x <= ix;
        vel_y <= iy;
        vel_z <= iz;
        seg_time <= d;
        in_valid <= 1;
        do @(posedge clk); while (!in_ready);
        predict_point(rt, ix, iy, iz, d, has, p);
        if (has) pending_q = {pending_q, p};
        sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        paddr <= {idx, 1'b0} << 1;
        pwdata <= val;
        pwrite <= 1;
        psel <= 1;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (idx == REG_TOP_SPEED) top_speed_q = val[14:0];
        else yaw_rate_q = val[15:0];
        @(posedge clk);
    endtask

    task automatic set_regs(logic [14:0] ts, logic [15:0] yr);
        wait_idle();
        apb_write(REG_TOP_SPEED, {17'd0, ts});
        apb_write(REG_YAW_RATE, {16'd0, yr});
    endtask

    function automatic logic [15:0] rnd_vel();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 600) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic rnd_forward();
        logic [15:0] d;
        d = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 8)) : 16'($urandom);
        send_point(0, rnd_vel(), rnd_vel(), rnd_vel(), d);
    endtask

    task automatic test_directed();
        send_point(1, 0, 0, 0, 0);
        send_point(0, 0, 0, 0, 100);
        send_point(0, 256, 0, 0, 0);
        send_point(0, 256, 0, 0, 256);
        send_point(0, -32768, -32768, -32768, 16'hffff);
        send_point(0, 32767, 32767, 32767, 1);
        send_point(0, 1, 0, 0, 1);
        send_point(0, 0, -1, 0, 16'hffff);
        send_point(0, 0, 0, -32768, 1000);
        send_point(0, 3, 4, 0, 500);
        for (int i = 0; i < 11; i++) send_point(1, -1, -1, -1, 16'hffff);
    endtask

    task automatic test_top_speed_extremes();
        set_regs(15'd1, 16'hffff);
        send_point(0, 32767, 0, 0, 16'hffff);
        send_point(0, -32768, 0, 0, 1);
        send_point(0, 100, -100, 100, 300);
        set_regs(15'h7fff, 16'd0);
        send_point(0, 1, 0, 0, 16'hffff);
        send_point(0, -1, 0, 0, 1);
        send_point(0, 200, 200, -200, 256);
        for (int i = 0; i < 6; i++) send_point(1, 0, 0, 0, 0);
    endtask

    task automatic test_random_mix(int n, bit stalls);
        stall_en = stalls;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 2) == 0)
                send_point(1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            else rnd_forward();
        end
        stall_en = 1;
    endtask

    task automatic test_buffer_overflow();
        set_regs(15'd512, 16'd4000);
        while (count_q < NPTS) rnd_forward();
        repeat (20) rnd_forward();
        while (replay_q < count_q && replay_q < NPTS) send_point(1, 0, 0, 0, 0);
        send_point(1, 0, 0, 0, 0);
        send_point(0, 256, 256, 256, 256);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        test_top_speed_extremes();
        set_regs(15'($urandom_range(1, 32767)), 16'($urandom));
        test_random_mix(200, 1);
        set_regs(15'd256, 16'd20000);
        test_random_mix(150, 0);
        set_regs(15'($urandom_range(1, 2000)), 16'($urandom_range(0, 65535)));
        test_random_mix(200, 1);
        test_buffer_overflow();
        wait_idle();
        $display("sent %0d items, checked %0d words (%0d return path)",
                 sent, checked, returns_seen);
        $display("covered top speed and yaw rate extremes, drops, replay and buffer full");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: trajectory_speed_normalizer_top.f
rtl/core/tsn_pkg.sv
rtl/core/trajectory_speed_normalizer_top.sv
rtl/core/tsn_checker.sv
dv/testbench.sv
